### rtl/tccw_pkg.sv
package tccw_pkg;

  // Default geometry
  localparam int DEF_SCREEN_WIDTH  = 80;
  localparam int DEF_SCREEN_HEIGHT = 25;
  localparam int DEF_TAB_STOP      = 4;

  // Field widths
  localparam int CELL_W         = 16;
  localparam int KIND_W         = 2;
  localparam int CHAR_W         = 8;
  localparam int CELL_INDEX_W   = 11;
  localparam int NEW_COLUMN_W   = 7;
  localparam int NEW_ROW_W      = 5;
  localparam int CURSOR_POS_W   = 11;
  localparam int COLOR_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 4;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE      = 2'd0,
    KIND_READ       = 2'd1,
    KIND_SET_CURSOR = 2'd2
  } kind_e;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK      = 2'd2;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  // Space, light grey on black
  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [CHAR_W-1:0]       char_code;
    logic [CELL_INDEX_W-1:0] cell_index;
    logic [NEW_COLUMN_W-1:0] new_column;
    logic [NEW_ROW_W-1:0]    new_row;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0]       read_char;
    logic [CHAR_W-1:0]       read_attr;
    logic [CURSOR_POS_W-1:0] cursor_position;
  } rsp_t;

  // Cell layout: blink and background bit 3 share bit 15
  function automatic logic [CELL_W-1:0] make_cell(
    input logic [CHAR_W-1:0]  ch,
    input logic [COLOR_W-1:0] fg,
    input logic [COLOR_W-1:0] bg,
    input logic               blink
  );
    return {bg[3] | blink, bg[2:0], fg, ch};
  endfunction

endpackage

### rtl/tccw_if.sv
// Command channel
interface tccw_cmd_if import tccw_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// Result channel
interface tccw_rsp_if import tccw_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/text_console_char_writer_unit.sv
// Text console character writer. The screen lives in one single-port-write,
// registered-read RAM of SCREEN_WIDTH*SCREEN_HEIGHT 16-bit cells; the cursor
// and colors sit in flip-flops. After reset the block runs a clearing pass
// that fills every cell with a grey-on-black space; no item is taken during
// it, but configuration writes are. One item is worked on at a time. A cell
// read goes through the registered RAM read port; a tab writes spaces up to
// the tab stop. Any step that moves past the last row scrolls the screen
// through the single RAM write port, one cell a cycle. Results leave through
// an output register, so a new item is taken while the previous result
// still waits at the output.
module text_console_char_writer_unit import tccw_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int TAB_STOP      = DEF_TAB_STOP
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tccw_cmd_if.sink              cmd_i,
  tccw_rsp_if.source            rsp_o
);

  localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AddrW      = $clog2(CELL_COUNT);
  localparam int ColW       = $clog2(SCREEN_WIDTH);
  localparam int RowW       = $clog2(SCREEN_HEIGHT);
  localparam int LeftW      = $clog2(TAB_STOP + 1);
  localparam int MoveCnt    = CELL_COUNT - SCREEN_WIDTH;
  localparam int PosW       = (AddrW > CURSOR_POS_W) ? AddrW : CURSOR_POS_W;
  localparam int ColTblN    = 2 ** NEW_COLUMN_W;
  localparam int RowTblN    = 2 ** NEW_ROW_W;
  localparam int TabTblN    = 2 ** ColW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_TAB,
    ST_SCROLL,
    ST_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [LeftW-1:0]     left_q, left_d;
  logic [AddrW:0]       rp_q, rp_d;
  logic [AddrW-1:0]     wp_q, wp_d;
  logic                 rd_pend_q, rd_pend_d;
  logic                 out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]    rc_q, rc_d, ra_q, ra_d;
  rsp_t                 out_q, out_d;
  logic [COLOR_W-1:0]   fg_q, bg_q;
  logic                 blink_q;

  logic                 mem_we, mem_re;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0]    mem_wdata, mem_rdata;

  cmd_t                 cmd;
  logic                 cmd_accept;
  logic                 go_scroll;
  logic [AddrW-1:0]     cur_addr;
  logic [PosW-1:0]      pos_wide;
  logic [CURSOR_POS_W-1:0] cur_pos;
  logic                 at_last_col, at_last_row;
  logic [RowW-1:0]      nl_row;
  logic [ColW-1:0]      adv_col;
  logic [RowW-1:0]      adv_row;
  logic                 adv_scroll;
  logic [CELL_W-1:0]    space_cell;

  // Constant tables: set-cursor modulo and tab distance
  logic [ColW-1:0]  col_mod_tbl [ColTblN];
  logic [RowW-1:0]  row_mod_tbl [RowTblN];
  logic [LeftW-1:0] tab_left_tbl [TabTblN];

  for (genvar v = 0; v < ColTblN; v++) begin : g_col_mod
    assign col_mod_tbl[v] = ColW'(v % SCREEN_WIDTH);
  end
  for (genvar v = 0; v < RowTblN; v++) begin : g_row_mod
    assign row_mod_tbl[v] = RowW'(v % SCREEN_HEIGHT);
  end
  for (genvar v = 0; v < TabTblN; v++) begin : g_tab_left
    assign tab_left_tbl[v] = LeftW'(TAB_STOP - (v % TAB_STOP));
  end

  assign cmd        = cmd_i.payload;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_accept = cmd_i.valid && cmd_i.ready;

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // Cursor address and reported position
  assign cur_addr = AddrW'(col_q) + AddrW'(row_q) * AddrW'(SCREEN_WIDTH);
  assign pos_wide = PosW'(cur_addr);
  assign cur_pos  = pos_wide[CURSOR_POS_W-1:0];

  assign space_cell = make_cell(CH_SPACE, fg_q, bg_q, blink_q);

  // Cursor stepping
  assign at_last_col = (col_q == ColW'(SCREEN_WIDTH - 1));
  assign at_last_row = (row_q == RowW'(SCREEN_HEIGHT - 1));
  assign nl_row      = at_last_row ? row_q : row_q + 1'b1;
  assign adv_col     = at_last_col ? '0 : col_q + 1'b1;
  assign adv_row     = at_last_col ? nl_row : row_q;
  assign adv_scroll  = at_last_col && at_last_row;

  // Sequencer and RAM port control
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    left_d      = left_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    rd_pend_d   = 1'b0;
    rc_d        = rc_q;
    ra_d        = ra_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    go_scroll   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cur_addr;
    mem_wdata   = space_cell;
    mem_re      = 1'b0;
    mem_raddr   = AddrW'(cmd.cell_index);

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = wp_q;
        mem_wdata = CELL_RESET;
        if (wp_q == AddrW'(CELL_COUNT - 1)) begin
          wp_d    = '0;
          state_d = ST_IDLE;
        end else begin
          wp_d = wp_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (cmd_accept) begin
          rc_d    = '0;
          ra_d    = '0;
          state_d = ST_DONE;
          unique case (cmd.kind)
            KIND_WRITE: begin
              unique case (cmd.char_code)
                CH_NEWLINE: begin
                  col_d     = '0;
                  row_d     = nl_row;
                  go_scroll = at_last_row;
                end
                CH_TAB: begin
                  left_d  = tab_left_tbl[col_q];
                  state_d = ST_TAB;
                end
                CH_RETURN: begin
                  col_d = '0;
                end
                CH_BACKSPACE: begin
                  if (col_q != '0) begin
                    col_d = col_q - 1'b1;
                  end else if (row_q != '0) begin
                    row_d = row_q - 1'b1;
                    col_d = ColW'(SCREEN_WIDTH - 1);
                  end
                end
                default: begin
                  mem_we    = 1'b1;
                  mem_wdata = make_cell(cmd.char_code, fg_q, bg_q, blink_q);
                  col_d     = adv_col;
                  row_d     = adv_row;
                  go_scroll = adv_scroll;
                end
              endcase
            end
            KIND_READ: begin
              if (int'(cmd.cell_index) < CELL_COUNT) begin
                mem_re  = 1'b1;
                state_d = ST_READ;
              end
            end
            KIND_SET_CURSOR: begin
              col_d = col_mod_tbl[cmd.new_column];
              row_d = row_mod_tbl[cmd.new_row];
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        rc_d    = mem_rdata[CHAR_W-1:0];
        ra_d    = mem_rdata[CELL_W-1:CHAR_W];
        state_d = ST_DONE;
      end

      // One space per cycle up to the tab stop, paused while a scroll runs
      ST_TAB: begin
        mem_we    = 1'b1;
        left_d    = left_q - 1'b1;
        col_d     = adv_col;
        row_d     = adv_row;
        go_scroll = adv_scroll;
        if (left_q == LeftW'(1)) begin
          state_d = ST_DONE;
        end
      end

      // Reads run one row ahead of the writes; bottom row refilled last
      ST_SCROLL: begin
        if (rp_q < (AddrW + 1)'(CELL_COUNT)) begin
          mem_re    = 1'b1;
          mem_raddr = rp_q[AddrW-1:0];
          rp_d      = rp_q + 1'b1;
          rd_pend_d = 1'b1;
        end
        if (wp_q < AddrW'(MoveCnt)) begin
          if (rd_pend_q) begin
            mem_we    = 1'b1;
            mem_waddr = wp_q;
            mem_wdata = make_cell(mem_rdata[CHAR_W-1:0], fg_q, bg_q, blink_q);
            wp_d      = wp_q + 1'b1;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = wp_q;
          if (wp_q == AddrW'(CELL_COUNT - 1)) begin
            wp_d    = '0;
            state_d = (left_q != '0) ? ST_TAB : ST_DONE;
          end else begin
            wp_d = wp_q + 1'b1;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d           = 1'b1;
          out_d.read_char       = rc_q;
          out_d.read_attr       = ra_q;
          out_d.cursor_position = cur_pos;
          state_d               = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (go_scroll) begin
      rp_d    = (AddrW + 1)'(SCREEN_WIDTH);
      wp_d    = '0;
      state_d = ST_SCROLL;
    end
  end

  // Control state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      left_q      <= left_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    rc_q  <= rc_d;
    ra_q  <= ra_d;
    out_q <= out_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q    <= FG_RESET;
      bg_q    <= BG_RESET;
      blink_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FOREGROUND: fg_q    <= cfg_data_i[COLOR_W-1:0];
        CFG_BACKGROUND: bg_q    <= cfg_data_i[COLOR_W-1:0];
        CFG_BLINK:      blink_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Cursor never leaves the screen
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(col_q) < SCREEN_WIDTH) && (int'(row_q) < SCREEN_HEIGHT))
    else $error("cursor outside the screen");

  // Scroll write pointer trails the read pointer by one row plus one
  a_scroll_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && rd_pend_q) |->
      (int'(wp_q) + SCREEN_WIDTH + 1 == int'(rp_q)))
    else $error("scroll read and write pointers out of step");

  // A tab in progress always has spaces left to write
  a_tab_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAB) |-> (left_q != '0))
    else $error("tab sequencer running with no spaces left");

  // The screen is only written by an accepted item or a running sequence
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !cmd_accept) |-> !mem_we)
    else $error("screen write while idle");

endmodule

### rtl/tccw_ram.sv
module tccw_ram import tccw_pkg::*; #(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = DEF_SCREEN_WIDTH * DEF_SCREEN_HEIGHT,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### tb/text_console_char_writer_unit_tb.sv
`timescale 1ns / 1ps

module text_console_char_writer_unit_tb;
  import tccw_pkg::*;

  // Geometry of the default build
  localparam int COLS  = DEF_SCREEN_WIDTH;
  localparam int ROWS  = DEF_SCREEN_HEIGHT;
  localparam int CELLS = COLS * ROWS;
  localparam int TABW  = DEF_TAB_STOP;

  // Kind code with no operation behind it
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 112;
  localparam int MAX_REPORTS     = 10;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tccw_cmd_if cmd_if ();
  tccw_rsp_if rsp_if ();

  text_console_char_writer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_if),
    .rsp_o      (rsp_if)
  );

  // Items waiting to be sent, responses waiting to arrive
  cmd_t pending_cmds[$];
  rsp_t expected_rsps[$];

  int send_idle_pct;
  int stall_pct;
  int mismatch_count;
  rsp_t oldest_rsp;

  // Shadow console state
  logic [CELL_W-1:0]  shadow_cells [CELLS];
  int                 cur_col;
  int                 cur_row;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic               blink_on;

  // Clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Cell in the current colors; blink shares the top bit with background
  function automatic logic [CELL_W-1:0] colored_cell(input logic [CHAR_W-1:0] ch);
    return {bg_color, fg_color, ch} | {blink_on, 15'd0};
  endfunction

  function automatic void scroll_up();
    for (int i = 0; i < CELLS; i++) begin
      if (i < CELLS - COLS)
        shadow_cells[i] = colored_cell(shadow_cells[i + COLS][CHAR_W-1:0]);
      else
        shadow_cells[i] = colored_cell(CH_SPACE);
    end
  endfunction

  function automatic void line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      cur_row = ROWS - 1;
      scroll_up();
    end
  endfunction

  function automatic void store_and_advance(input logic [CHAR_W-1:0] ch);
    shadow_cells[cur_col + cur_row * COLS] = colored_cell(ch);
    cur_col++;
    if (cur_col >= COLS) line_feed();
  endfunction

  function automatic void type_char(input logic [CHAR_W-1:0] ch);
    int gap;
    case (ch)
      CH_NEWLINE: line_feed();
      CH_TAB: begin
        gap = TABW - (cur_col % TABW);
        for (int i = 0; i < gap; i++) store_and_advance(CH_SPACE);
      end
      CH_RETURN: cur_col = 0;
      CH_BACKSPACE: begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = COLS - 1;
        end
      end
      default: store_and_advance(ch);
    endcase
  endfunction

  // Apply one item to the shadow console and return its response
  function automatic rsp_t console_response(input cmd_t c);
    rsp_t r;
    int pos;
    r = '0;
    case (c.kind)
      KIND_WRITE: type_char(c.char_code);
      KIND_READ: begin
        if (int'(c.cell_index) < CELLS) begin
          r.read_char = shadow_cells[c.cell_index][CHAR_W-1:0];
          r.read_attr = shadow_cells[c.cell_index][CELL_W-1:CHAR_W];
        end
      end
      KIND_SET_CURSOR: begin
        cur_col = int'(c.new_column) % COLS;
        cur_row = int'(c.new_row) % ROWS;
      end
      default: ;
    endcase
    pos = cur_col + cur_row * COLS;
    r.cursor_position = pos[CURSOR_POS_W-1:0];
    return r;
  endfunction

  // Item with every field random
  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.kind       = KIND_W'($urandom_range(3));
    c.char_code  = CHAR_W'($urandom_range(255));
    c.cell_index = CELL_INDEX_W'($urandom_range(2047));
    c.new_column = NEW_COLUMN_W'($urandom_range(127));
    c.new_row    = NEW_ROW_W'($urandom_range(31));
    return c;
  endfunction

  function automatic cmd_t write_cmd(input logic [CHAR_W-1:0] ch);
    cmd_t c;
    c = noise_cmd();
    c.kind = KIND_WRITE;
    c.char_code = ch;
    return c;
  endfunction

  function automatic cmd_t read_cmd(input int idx);
    cmd_t c;
    c = noise_cmd();
    c.kind = KIND_READ;
    c.cell_index = CELL_INDEX_W'(idx);
    return c;
  endfunction

  function automatic cmd_t cursor_cmd(input int col, input int row);
    cmd_t c;
    c = noise_cmd();
    c.kind = KIND_SET_CURSOR;
    c.new_column = NEW_COLUMN_W'(col);
    c.new_row = NEW_ROW_W'(row);
    return c;
  endfunction

  // Unused kind with random other fields
  function automatic cmd_t unused_cmd();
    cmd_t c;
    c = noise_cmd();
    c.kind = KIND_UNUSED;
    return c;
  endfunction

  // Mostly text, with control codes, reads and cursor moves biased toward
  // the bottom right so that wraps and scrolls happen often enough
  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    c = noise_cmd();
    pick = $urandom_range(99);
    if (pick < 50) begin
      c = write_cmd(CHAR_W'($urandom_range(255)));
    end else if (pick < 58) begin
      c = write_cmd(CH_NEWLINE);
    end else if (pick < 63) begin
      c = write_cmd(CH_TAB);
    end else if (pick < 67) begin
      c = write_cmd(CH_RETURN);
    end else if (pick < 71) begin
      c = write_cmd(CH_BACKSPACE);
    end else if (pick < 86) begin
      if ($urandom_range(1) == 1)
        c = read_cmd($urandom_range(CELLS - 1, CELLS - 3 * COLS));
      else
        c = read_cmd($urandom_range(2047));
    end else if (pick < 97) begin
      if ($urandom_range(99) < 40)
        c = cursor_cmd($urandom_range(79, 70), $urandom_range(24, 22));
      else
        c = cursor_cmd($urandom_range(127), $urandom_range(31));
    end else begin
      c.kind = KIND_UNUSED;
    end
    return c;
  endfunction

  // Register write; the block is idle whenever this is called
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_FOREGROUND: fg_color = value;
      CFG_BACKGROUND: bg_color = value;
      CFG_BLINK:      blink_on = value[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                            input logic blink);
    set_register(CFG_FOREGROUND, fg);
    set_register(CFG_BACKGROUND, bg);
    set_register(CFG_BLINK, {3'b000, blink});
  endtask

  // Sampled on the falling edge so queue updates at the rising edge are settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_rsps.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) pending_cmds.push_back(random_cmd());
  endtask

  // Command driver: predicts on acceptance, then offers the next item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready)
        expected_rsps.push_back(console_response(cmd_if.payload));
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_if.valid   <= 1'b1;
          cmd_if.payload <= pending_cmds.pop_front();
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected response: char %0d attr %0h pos %0d",
                   rsp_if.payload.read_char, rsp_if.payload.read_attr,
                   rsp_if.payload.cursor_position);
      end else begin
        oldest_rsp = expected_rsps.pop_front();
        if (rsp_if.payload.read_char !== oldest_rsp.read_char ||
            rsp_if.payload.read_attr !== oldest_rsp.read_attr ||
            rsp_if.payload.cursor_position !== oldest_rsp.cursor_position) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: char %0d/%0d attr %0h/%0h pos %0d/%0d (exp/got)",
                     oldest_rsp.read_char, rsp_if.payload.read_char,
                     oldest_rsp.read_attr, rsp_if.payload.read_attr,
                     oldest_rsp.cursor_position, rsp_if.payload.cursor_position);
        end
      end
    end
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // Stimulus sequence
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    rsp_if.ready   = 1'b0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    mismatch_count = 0;
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = CELL_RESET;
    cur_col  = 0;
    cur_row  = 0;
    fg_color = FG_RESET;
    bg_color = BG_RESET;
    blink_on = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset contents, range ends, control codes, wraps and scrolls
    pending_cmds.push_back(read_cmd(0));
    pending_cmds.push_back(read_cmd(CELLS - 1));
    pending_cmds.push_back(read_cmd(CELLS));
    pending_cmds.push_back(read_cmd(2047));
    pending_cmds.push_back(write_cmd(8'h41));
    pending_cmds.push_back(write_cmd(8'hFF));
    pending_cmds.push_back(write_cmd(8'h00));
    pending_cmds.push_back(write_cmd(CH_TAB));        // single space to col 4
    pending_cmds.push_back(write_cmd(CH_TAB));        // full tab to col 8
    pending_cmds.push_back(write_cmd(CH_BACKSPACE));
    pending_cmds.push_back(write_cmd(CH_RETURN));
    pending_cmds.push_back(write_cmd(CH_BACKSPACE));  // at home: no move
    pending_cmds.push_back(write_cmd(CH_NEWLINE));
    pending_cmds.push_back(write_cmd(CH_BACKSPACE));  // back to end of row 0
    pending_cmds.push_back(write_cmd(8'h7E));         // wraps to row 1
    pending_cmds.push_back(read_cmd(1));
    pending_cmds.push_back(cursor_cmd(127, 31));      // both taken modulo
    pending_cmds.push_back(unused_cmd());
    pending_cmds.push_back(cursor_cmd(COLS - 1, ROWS - 1));
    pending_cmds.push_back(write_cmd(8'h5A));         // wrap on last row scrolls
    pending_cmds.push_back(read_cmd(CELLS - COLS - 1));
    pending_cmds.push_back(cursor_cmd(COLS - 2, ROWS - 1));
    pending_cmds.push_back(write_cmd(CH_TAB));        // tab that scrolls
    pending_cmds.push_back(write_cmd(CH_NEWLINE));    // newline on last row
    pending_cmds.push_back(read_cmd(CELLS - 2));
    wait_idle();

    // Random phases under different colors and idling
    set_colors(4'hF, 4'hF, 1'b1);
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    set_colors(4'h0, 4'h0, 1'b0);
    send_idle_pct = 54;
    stall_pct     = 0;
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    set_colors(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)),
               1'($urandom_range(1)));
    send_idle_pct = 0;
    stall_pct     = 54;
    queue_random(ITEMS_PER_PHASE / 2);
    wait_idle();                                      // sender holds until drained
    queue_random(ITEMS_PER_PHASE / 2);
    wait_idle();

    set_colors(COLOR_W'($urandom_range(15)), 4'h8, 1'b0);
    send_idle_pct = 8;
    stall_pct     = 8;
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
